FILE: hw/rtl/drr_pkg.sv
// Package for the deficit round robin scheduler: payload structs, status codes,
// configuration register indexes and reset defaults. No dependencies.
package drr_pkg;

    localparam int DEF_QUEUE_DEPTH = 128;
    localparam int DEF_NUM_CLASSES = 5;
    localparam int NUM_QUANTA      = 5;

    localparam int LEN_W   = 16;
    localparam int TAG_W   = 16;
    localparam int PORT_W  = 16;
    localparam int LIMIT_W = 23;
    localparam int QNT_W   = 16;
    localparam int DEF_W   = 17;
    localparam int CFG_W   = 23;
    localparam int CFG_IDX_W = 3;

    localparam logic [0:0] ACT_ENQ = 1'b0;
    localparam logic [0:0] ACT_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_SENT     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_BASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0    = 3'd3;

    localparam logic [LIMIT_W-1:0] RST_QUEUE_LIMIT = 23'd100;
    localparam logic [PORT_W-1:0]  RST_PORT_BASE   = 16'd3000;
    localparam logic [QNT_W-1:0]   RST_QUANTUM     = 16'd1;

    typedef struct packed {
        logic              action;
        logic [PORT_W-1:0] dest_port;
        logic [LEN_W-1:0]  pkt_len;
        logic [TAG_W-1:0]  pkt_tag;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [2:0]       traffic_class;
        logic [LEN_W-1:0] sent_len;
        logic [TAG_W-1:0] sent_tag;
    } t_out;

endpackage

FILE: hw/rtl/drr_desc_mem.sv
// Descriptor store of the scheduler: one write port, one read port with
// registered read data. Uses drr_pkg for the descriptor widths.
module drr_desc_mem
    import drr_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH * DEF_NUM_CLASSES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [LEN_W+TAG_W-1:0]   i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [LEN_W+TAG_W-1:0]   o_rdata
);

    logic [LEN_W+TAG_W-1:0] r_mem [DEPTH];
    logic [LEN_W+TAG_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/deficit_round_robin_scheduler_core.sv
// Top level of the deficit round robin packet scheduler.
// Depends on drr_pkg and drr_desc_mem.
//
//   channel   direction  handshake                  payload
//   in        request    i_in_valid / o_in_stall    i_in_data  (t_in)
//   out       result     o_out_valid / i_out_stall  o_out_data (t_out)
//   cfg       write      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// An enqueue passes through S_ENQ. A dequeue passes through S_DEQ, then S_VISIT
// for each empty class skipped and S_VISIT then S_READ for each visit of an active
// class (descriptor read, then compare), so it grows with packet length over quantum.
// Reset is synchronous and clears all control and per-class counters.
// A result waits in the output register while the next request is accepted;
// a stalled output holds the scheduler in the state that produces the result.
module deficit_round_robin_scheduler_core
    import drr_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int MEM_DEPTH = QUEUE_DEPTH * NUM_CLASSES;
    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int PW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int BW  = LEN_W + CW;
    localparam int SW  = ((BW > LIMIT_W) ? BW : LIMIT_W) + 1;
    localparam int CLW = $clog2(NUM_CLASSES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ENQ   = 3'd1;
    localparam logic [2:0] S_DEQ   = 3'd2;
    localparam logic [2:0] S_VISIT = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;

    logic [2:0] r_state, n_state;

    logic                 r_limit_mode;
    logic [LIMIT_W-1:0]   r_queue_limit;
    logic [PORT_W-1:0]    r_port_base;
    logic [QNT_W-1:0]     r_quanta [NUM_QUANTA];

    logic [PW-1:0]    r_head  [NUM_CLASSES];
    logic [PW-1:0]    r_tail  [NUM_CLASSES];
    logic [CW-1:0]    r_count [NUM_CLASSES];
    logic [BW-1:0]    r_bytes [NUM_CLASSES];
    logic [DEF_W-1:0] r_def   [NUM_CLASSES];
    logic [CLW-1:0]   r_cur;
    logic             r_started;

    t_in              r_req;
    logic [CLW-1:0]   r_cls;
    logic             r_out_valid, n_out_valid;
    t_out             r_out;

    logic             out_free;
    logic [PORT_W-1:0] diff;
    logic [CLW-1:0]   in_cls;
    logic             any_busy;
    logic [QNT_W-1:0] quantum;
    logic [CLW-1:0]   cur_next;
    logic [SW-1:0]    byte_sum;
    logic             drop;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [LEN_W+TAG_W-1:0] mem_rdata;
    logic [LEN_W-1:0] hlen;
    logic             fits;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        diff = i_in_data.dest_port - r_port_base;
        if (i_in_data.dest_port >= r_port_base
                && {16'd0, diff} < 32'(NUM_CLASSES - 1)) begin
            in_cls = diff[CLW-1:0];
        end else begin
            in_cls = CLW'(NUM_CLASSES - 1);
        end
    end

    always_comb begin
        any_busy = 1'b0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (r_count[i] != '0) begin
                any_busy = 1'b1;
            end
        end
    end

    always_comb begin
        logic [QNT_W-1:0] q;
        q = ({29'd0, r_cur} >= 32'(NUM_QUANTA - 1)) ? r_quanta[NUM_QUANTA-1]
                                                    : r_quanta[r_cur];
        quantum = (q == '0) ? RST_QUANTUM : q;
    end

    assign cur_next = ({29'd0, r_cur} == 32'(NUM_CLASSES - 1)) ? '0 : r_cur + 1'b1;

    assign byte_sum = SW'(r_bytes[r_cls]) + SW'(r_req.pkt_len);
    always_comb begin
        drop = 1'b0;
        if (!r_limit_mode && SW'(r_count[r_cls]) >= SW'(r_queue_limit)) begin
            drop = 1'b1;
        end
        if (r_limit_mode && byte_sum >= SW'(r_queue_limit)) begin
            drop = 1'b1;
        end
        if (32'(r_count[r_cls]) >= 32'(QUEUE_DEPTH)) begin
            drop = 1'b1;
        end
    end

    assign mem_we    = (r_state == S_ENQ) && out_free && !drop;
    assign mem_waddr = AW'(r_cls * QUEUE_DEPTH) + AW'(r_tail[r_cls]);
    assign mem_re    = (r_state == S_VISIT) && (r_count[r_cur] != '0);
    assign mem_raddr = AW'(r_cur * QUEUE_DEPTH) + AW'(r_head[r_cur]);
    assign hlen      = mem_rdata[LEN_W+TAG_W-1:TAG_W];
    assign fits      = {1'b0, hlen} <= r_def[r_cur];

    drr_desc_mem #(
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata ({r_req.pkt_len, r_req.pkt_tag}),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_data.action == ACT_ENQ) ? S_ENQ : S_DEQ;
                end
            end
            S_ENQ: begin
                if (out_free) n_state = S_IDLE;
            end
            S_DEQ: begin
                if (!any_busy) begin
                    if (out_free) n_state = S_IDLE;
                end else begin
                    n_state = S_VISIT;
                end
            end
            S_VISIT: begin
                if (r_count[r_cur] != '0) n_state = S_READ;
            end
            S_READ: begin
                if (!fits) begin
                    n_state = S_VISIT;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // A result is loaded in the same cycle the previous one may leave.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_ENQ: begin
                if (out_free) n_out_valid = 1'b1;
            end
            S_DEQ: begin
                if (!any_busy && out_free) n_out_valid = 1'b1;
            end
            S_READ: begin
                if (fits && out_free) n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_limit_mode  <= 1'b0;
            r_queue_limit <= RST_QUEUE_LIMIT;
            r_port_base   <= RST_PORT_BASE;
            for (int i = 0; i < NUM_QUANTA; i++) r_quanta[i] <= RST_QUANTUM;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
                r_bytes[i] <= '0;
                r_def[i]   <= '0;
            end
            r_cur       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LIMIT_MODE:  r_limit_mode  <= i_cfg_data[0];
                    CFG_QUEUE_LIMIT: r_queue_limit <= i_cfg_data[LIMIT_W-1:0];
                    CFG_PORT_BASE:   r_port_base   <= i_cfg_data[PORT_W-1:0];
                    default: r_quanta[i_cfg_idx - CFG_QUANTUM0] <= i_cfg_data[QNT_W-1:0];
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req <= i_in_data;
                        r_cls <= in_cls;
                    end
                end
                S_ENQ: begin
                    if (out_free) begin
                        r_out.status        <= drop ? ST_DROPPED : ST_ENQUEUED;
                        r_out.traffic_class <= 3'(r_cls);
                        r_out.sent_len      <= '0;
                        r_out.sent_tag      <= '0;
                        if (!drop) begin
                            r_tail[r_cls]  <= (32'(r_tail[r_cls]) == 32'(QUEUE_DEPTH - 1))
                                              ? '0 : r_tail[r_cls] + 1'b1;
                            r_count[r_cls] <= r_count[r_cls] + 1'b1;
                            r_bytes[r_cls] <= r_bytes[r_cls] + BW'(r_req.pkt_len);
                        end
                    end
                end
                S_DEQ: begin
                    if (!any_busy && out_free) begin
                        r_out.status        <= ST_EMPTY;
                        r_out.traffic_class <= '0;
                        r_out.sent_len      <= '0;
                        r_out.sent_tag      <= '0;
                    end
                end
                S_VISIT: begin
                    if (r_count[r_cur] == '0) begin
                        r_def[r_cur] <= '0;
                        r_started    <= 1'b0;
                        r_cur        <= cur_next;
                    end else if (!r_started) begin
                        r_def[r_cur] <= r_def[r_cur] + DEF_W'(quantum);
                        r_started    <= 1'b1;
                    end
                end
                S_READ: begin
                    if (!fits) begin
                        r_started <= 1'b0;
                        r_cur     <= cur_next;
                    end else if (out_free) begin
                        r_out.status        <= ST_SENT;
                        r_out.traffic_class <= 3'(r_cur);
                        r_out.sent_len      <= hlen;
                        r_out.sent_tag      <= mem_rdata[TAG_W-1:0];
                        r_bytes[r_cur] <= r_bytes[r_cur] - BW'(hlen);
                        r_count[r_cur] <= r_count[r_cur] - 1'b1;
                        r_head[r_cur]  <= (32'(r_head[r_cur]) == 32'(QUEUE_DEPTH - 1))
                                          ? '0 : r_head[r_cur] + 1'b1;
                        // The class empties with this packet: clear and move on.
                        if (r_count[r_cur] == CW'(1)) begin
                            r_def[r_cur] <= '0;
                            r_started    <= 1'b0;
                            r_cur        <= cur_next;
                        end else begin
                            r_def[r_cur] <= r_def[r_cur] - DEF_W'(hlen);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
